/* rtl/core/masked_ip_filter_table_top_macros.svh */
// assertion helpers used by the checker file
`ifndef MASKED_IP_FILTER_TABLE_TOP_MACROS_SVH
`define MASKED_IP_FILTER_TABLE_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define MIFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MIFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mift_pkg.sv */
package mift_pkg;

  // table geometry
  localparam int MaxFilters = 1024;
  localparam int AddrW      = $clog2(MaxFilters);
  localparam int CountW     = AddrW + 1;
  localparam int WordW      = 32;

  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [WordW-1:0]  word_t;

  localparam count_t MaxCount = count_t'(MaxFilters);
  localparam word_t  FreeMark = 32'hffff_ffff;

  // operation codes
  typedef logic [1:0] func_t;
  localparam func_t FUNC_ADD    = 2'd0;
  localparam func_t FUNC_REMOVE = 2'd1;
  localparam func_t FUNC_CHECK  = 2'd2;

  // result codes
  typedef logic [2:0] status_t;
  localparam status_t ST_ADDED     = 3'd0;
  localparam status_t ST_FULL      = 3'd1;
  localparam status_t ST_REMOVED   = 3'd2;
  localparam status_t ST_NOT_FOUND = 3'd3;
  localparam status_t ST_CHECKED   = 3'd4;

  // table memory access: write port and read address
  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    addr_t raddr;
  } ram_req_t;

  // byte mask: all ones where the address byte is nonzero
  function automatic word_t wildcard_mask(input word_t word);
    word_t m;
    m = '0;
    for (int k = 0; k < 4; k++) begin
      if (word[8*k +: 8] != 8'd0) begin
        m[8*k +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

/* rtl/core/mift_in_if.sv */
interface mift_in_if;
  import mift_pkg::*;

  logic           valid;
  logic           ready;
  func_t          func;
  logic [7:0]     octet_a;
  logic [7:0]     octet_b;
  logic [7:0]     octet_c;
  logic [7:0]     octet_d;

  modport source (output valid, func, octet_a, octet_b, octet_c, octet_d, input ready);
  modport sink   (input valid, func, octet_a, octet_b, octet_c, octet_d, output ready);
endinterface

/* rtl/core/mift_out_if.sv */
interface mift_out_if;
  import mift_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  logic    allowed;
  count_t  entries_used;

  modport source (output valid, status, allowed, entries_used, input ready);
  modport sink   (input valid, status, allowed, entries_used, output ready);
endinterface

/* rtl/core/masked_ip_filter_table_top.sv */
// channel | direction | beat contents
// req     | in        | func, octet_a, octet_b, octet_c, octet_d
// rsp     | out       | status, allowed, entries_used
// cfg     | in        | cfg_we, cfg_wdata (ban_mode)
//
// one item at a time; the table is walked through the single read port of
// the entry memory, one entry per cycle with the read running one ahead
// check and add scan the used entries; remove also shifts the later entries down
// reset clears the entry count and sets ban_mode; the memory needs no clearing
// a stalled rsp holds the result register; the next req beat is taken meanwhile
module masked_ip_filter_table_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  mift_in_if.sink    req,
  mift_out_if.source rsp
);
  import mift_pkg::*;

  logic     ban_mode;
  ram_req_t ram_req;
  word_t    ram_rdata;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ban_mode <= 1'b1;
    end else if (cfg_we) begin
      ban_mode <= cfg_wdata;
    end
  end

  // sequencer
  mift_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .ban_mode  (ban_mode),
    .req       (req),
    .rsp       (rsp),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  // entry compare values; masks are rebuilt from them
  mift_ram #(
    .Width (WordW),
    .Depth (MaxFilters)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

/* rtl/core/mift_ram.sv */
module mift_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/mift_ctrl.sv */
module mift_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              ban_mode,
  mift_in_if.sink           req,
  mift_out_if.source        rsp,
  output mift_pkg::ram_req_t ram_req,
  input  mift_pkg::word_t   ram_rdata
);
  import mift_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  func_t      op;
  word_t      word;
  count_t     used;
  count_t     rd_idx;
  logic       pend;
  addr_t      pend_idx;
  status_t    res_status;
  logic       res_allowed;
  logic       out_valid;
  status_t    out_status;
  logic       out_allowed;
  count_t     out_used;

  word_t      entry_mask;
  logic       hit;
  logic       more;

  // compare the entry that came back from memory this cycle
  always_comb begin
    entry_mask = wildcard_mask(ram_rdata);
    more       = (rd_idx < used);
    hit        = 1'b0;
    if (pend) begin
      case (op)
        FUNC_ADD:    hit = (ram_rdata == FreeMark);
        // stored masks follow from the compare value, so equal compares imply equal masks
        FUNC_REMOVE: hit = (ram_rdata == word);
        FUNC_CHECK:  hit = ((word & entry_mask) == ram_rdata);
        default:     hit = 1'b0;
      endcase
    end
  end

  // memory port: read runs ahead by one entry, writes for add and for compaction
  always_comb begin
    ram_req.we    = 1'b0;
    ram_req.waddr = pend_idx;
    ram_req.wdata = word;
    ram_req.raddr = rd_idx[AddrW-1:0];
    case (state)
      S_SCAN: begin
        if (op == FUNC_ADD) begin
          if (hit) begin
            ram_req.we = 1'b1;
          end else if (!pend && !more && used != MaxCount) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = used[AddrW-1:0];
          end
        end
      end
      S_SHIFT: begin
        if (pend) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pend_idx - addr_t'(1);
          ram_req.wdata = ram_rdata;
        end
      end
      default: ram_req.we = 1'b0;
    endcase
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.allowed      = out_allowed;
  assign rsp.entries_used = out_used;

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op          <= req.func;
            word        <= {req.octet_d, req.octet_c, req.octet_b, req.octet_a};
            rd_idx      <= '0;
            pend        <= 1'b0;
            res_allowed <= 1'b0;
            if (req.func inside {FUNC_ADD, FUNC_REMOVE, FUNC_CHECK}) begin
              state <= S_SCAN;
            end else begin
              res_status <= ST_NOT_FOUND;
              state      <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          pend     <= more;
          pend_idx <= rd_idx[AddrW-1:0];
          if (more) begin
            rd_idx <= rd_idx + count_t'(1);
          end
          if (hit) begin
            case (op)
              FUNC_ADD: begin
                res_status <= ST_ADDED;
                state      <= S_DONE;
              end
              FUNC_REMOVE: begin
                // close the gap from the entry after the match
                rd_idx <= count_t'(pend_idx) + count_t'(1);
                pend   <= 1'b0;
                state  <= S_SHIFT;
              end
              default: begin
                res_status  <= ST_CHECKED;
                res_allowed <= ban_mode;
                state       <= S_DONE;
              end
            endcase
          end else if (!pend && !more) begin
            case (op)
              FUNC_ADD: begin
                if (used == MaxCount) begin
                  res_status <= ST_FULL;
                end else begin
                  used       <= used + count_t'(1);
                  res_status <= ST_ADDED;
                end
              end
              FUNC_REMOVE: res_status <= ST_NOT_FOUND;
              default: begin
                res_status  <= ST_CHECKED;
                res_allowed <= ~ban_mode;
              end
            endcase
            state <= S_DONE;
          end
        end
        S_SHIFT: begin
          pend     <= more;
          pend_idx <= rd_idx[AddrW-1:0];
          if (more) begin
            rd_idx <= rd_idx + count_t'(1);
          end
          if (!pend && !more) begin
            used       <= used - count_t'(1);
            res_status <= ST_REMOVED;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_status  <= res_status;
            out_allowed <= res_allowed;
            out_used    <= used;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/mift_checker.sv */
`include "masked_ip_filter_table_top_macros.svh"

module mift_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input mift_pkg::status_t rsp_status,
  input logic              rsp_allowed,
  input mift_pkg::count_t  rsp_entries_used
);
  import mift_pkg::*;

  // never more entries than the table holds
  `MIFT_ASSERT_NOW(a_used_bound, rsp_valid, rsp_entries_used <= MaxCount, "entry count over limit")

  // allowed is only raised by a check
  `MIFT_ASSERT_NOW(a_allowed_check, rsp_valid && rsp_status != ST_CHECKED, !rsp_allowed, "allowed set outside a check")

  // one item at a time: no beat right after an accepted one
  `MIFT_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "ready straight after accept")

  // a stalled result stays offered
  `MIFT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

endmodule

bind masked_ip_filter_table_top mift_checker u_chk (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_allowed      (rsp.allowed),
  .rsp_entries_used (rsp.entries_used)
);
